/* src/event_sort_reverse_ties_core_macros.svh */
// Assertion macros shared by the sorter modules.
`ifndef EVENT_SORT_REVERSE_TIES_CORE_MACROS_SVH
`define EVENT_SORT_REVERSE_TIES_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold at every clock edge outside reset.
`define ESRT_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ESRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ESRT_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ESRT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* src/esrt_pkg.sv */
package esrt_pkg;

   localparam int MAX_EVENTS  = 1024;
   localparam int TAG_BITS    = 32;

   localparam int TIME_W      = 64;
   localparam int TAG_OUT_W   = 32;
   localparam int STORE_TAG_W = (TAG_BITS < TAG_OUT_W) ? TAG_BITS : TAG_OUT_W;
   localparam int ADDR_W      = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
   localparam int CNT_W       = $clog2(MAX_EVENTS + 1);

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_RETURNED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_DROPPED  = 2'd3
   } esrt_status_type;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_TAKE = 1'b1
   } esrt_req_cmd_type;

   typedef struct packed {
      logic [TIME_W-1:0]      key;
      logic [STORE_TAG_W-1:0] tag;
   } esrt_entry_type;

   // Controller to datapath
   typedef struct packed {
      logic            capture;
      logic            clear_batch;
      logic            set_reading;
      logic            scan_load;
      logic            scan_step;
      logic            wr_shift;
      logic            wr_new_above;
      logic            wr_new_bottom;
      logic            inc_held;
      logic            rd_take;
      logic            inc_read;
      logic            respond;
      esrt_status_type rsp_status;
   } esrt_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic reading;
      logic full;
      logic batch_empty;
      logic more_left;
      logic scan_zero;
      logic key_ge;
   } esrt_stat_type;

endpackage

/* src/esrt_datapath.sv */
`include "event_sort_reverse_ties_core_macros.svh"

module esrt_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [esrt_pkg::TIME_W-1:0]         req_event_time,
   input  logic [esrt_pkg::TAG_OUT_W-1:0]      req_event_tag,
   input  esrt_pkg::esrt_cmd_type              cmd,
   output esrt_pkg::esrt_stat_type             stat,
   output logic                                rsp_strobe,
   output logic [1:0]                          rsp_status,
   output logic [esrt_pkg::TIME_W-1:0]         rsp_out_time,
   output logic [esrt_pkg::TAG_OUT_W-1:0]      rsp_out_tag,
   output logic                                rsp_final_one
);
   import esrt_pkg::*;

   esrt_entry_type mem [MAX_EVENTS];
   esrt_entry_type rdata_ff;
   esrt_entry_type new_ff;

   logic [CNT_W-1:0]  held_ff, held_in;
   logic [CNT_W-1:0]  read_idx_ff, read_idx_in;
   logic              reading_ff, reading_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;

   logic              rsp_valid_ff;
   esrt_status_type   rsp_status_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   logic [TAG_OUT_W-1:0] rsp_tag_ff;
   logic              rsp_final_ff;

   logic [ADDR_W-1:0] rd_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;
   esrt_entry_type    wr_data;
   logic [CNT_W-1:0]  read_idx_next;

   assign read_idx_next = read_idx_ff + CNT_W'(1);

   always_comb begin
      held_in    = held_ff;
      read_idx_in = read_idx_ff;
      reading_in = reading_ff;
      scan_in    = scan_ff;
      if (cmd.clear_batch) begin
         held_in     = '0;
         read_idx_in = '0;
         reading_in  = 1'b0;
      end
      if (cmd.set_reading) reading_in = 1'b1;
      if (cmd.inc_held) held_in = held_ff + CNT_W'(1);
      if (cmd.inc_read) read_idx_in = read_idx_next;
      if (cmd.scan_load) scan_in = ADDR_W'(held_ff - CNT_W'(1));
      if (cmd.scan_step) scan_in = scan_ff - ADDR_W'(1);
   end

   always_comb begin
      rd_en   = cmd.scan_load | cmd.scan_step | cmd.rd_take;
      rd_addr = read_idx_ff[ADDR_W-1:0];
      priority if (cmd.scan_load) rd_addr = ADDR_W'(held_ff - CNT_W'(1));
      else if (cmd.scan_step) rd_addr = scan_ff - ADDR_W'(1);
      else rd_addr = read_idx_ff[ADDR_W-1:0];
   end

   always_comb begin
      wr_en   = cmd.wr_shift | cmd.wr_new_above | cmd.wr_new_bottom;
      wr_addr = scan_ff + ADDR_W'(1);
      wr_data = new_ff;
      priority if (cmd.wr_shift) wr_data = rdata_ff;
      else if (cmd.wr_new_bottom) wr_addr = '0;
      else wr_addr = scan_ff + ADDR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_ff.key <= req_event_time;
         new_ff.tag <= STORE_TAG_W'(req_event_tag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         read_idx_ff  <= '0;
         reading_ff   <= 1'b0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         read_idx_ff  <= read_idx_in;
         reading_ff   <= reading_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff <= cmd.rsp_status;
         if (cmd.rsp_status == ST_RETURNED) begin
            rsp_time_ff  <= rdata_ff.key;
            rsp_tag_ff   <= TAG_OUT_W'(rdata_ff.tag);
            rsp_final_ff <= (read_idx_next == held_ff);
         end else begin
            rsp_time_ff  <= '0;
            rsp_tag_ff   <= '0;
            rsp_final_ff <= 1'b0;
         end
      end
   end

   assign stat.reading     = reading_ff;
   assign stat.full        = (held_ff >= CNT_W'(MAX_EVENTS));
   assign stat.batch_empty = (held_ff == '0);
   assign stat.more_left   = (read_idx_ff < held_ff);
   assign stat.scan_zero   = (scan_ff == '0);
   assign stat.key_ge      = (rdata_ff.key >= new_ff.key);

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_time  = rsp_time_ff;
   assign rsp_out_tag   = rsp_tag_ff;
   assign rsp_final_one = rsp_final_ff;

   `ESRT_ASSERT_ALWAYS(a_read_within_batch, clock, reset, read_idx_ff <= held_ff)
   `ESRT_ASSERT_ALWAYS(a_held_bounded, clock, reset, held_ff <= CNT_W'(MAX_EVENTS))
   `ESRT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)

endmodule

/* src/esrt_ctrl.sv */
`include "event_sort_reverse_ties_core_macros.svh"

module esrt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_cmd,
   input  esrt_pkg::esrt_stat_type stat,
   output esrt_pkg::esrt_cmd_type  cmd,
   output logic                    busy
);
   import esrt_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_PUSH     = 6'b000010,
      S_CMP      = 6'b000100,
      S_PLACE    = 6'b001000,
      S_TAKE     = 6'b010000,
      S_TAKE_OUT = 6'b100000
   } esrt_state_type;

   esrt_state_type state_ff, state_in;
   logic [2:0]     wr_sel;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_status = ST_ACCEPTED;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               if (esrt_req_cmd_type'(req_cmd) == CMD_TAKE) begin
                  cmd.set_reading = 1'b1;
                  state_in = S_TAKE;
               end else begin
                  // a push after reading began opens a new batch
                  cmd.clear_batch = stat.reading;
                  state_in = S_PUSH;
               end
            end
         end
         S_PUSH: begin
            priority if (stat.full) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_DROPPED;
               state_in = S_IDLE;
            end else if (stat.batch_empty) begin
               cmd.wr_new_bottom = 1'b1;
               cmd.inc_held      = 1'b1;
               cmd.respond       = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.scan_load = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // walk down from the top, shifting entries not below the new key
            if (stat.key_ge) begin
               cmd.wr_shift = 1'b1;
               if (stat.scan_zero) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.scan_step = 1'b1;
               end
            end else begin
               cmd.wr_new_above = 1'b1;
               cmd.inc_held     = 1'b1;
               cmd.respond      = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_PLACE: begin
            cmd.wr_new_bottom = 1'b1;
            cmd.inc_held      = 1'b1;
            cmd.respond       = 1'b1;
            state_in = S_IDLE;
         end
         S_TAKE: begin
            if (stat.more_left) begin
               cmd.rd_take = 1'b1;
               state_in = S_TAKE_OUT;
            end else begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_EMPTY;
               state_in = S_IDLE;
            end
         end
         S_TAKE_OUT: begin
            cmd.respond    = 1'b1;
            cmd.rsp_status = ST_RETURNED;
            cmd.inc_read   = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy   = (state_ff != S_IDLE);
   assign wr_sel = {cmd.wr_shift, cmd.wr_new_above, cmd.wr_new_bottom};

   `ESRT_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `ESRT_ASSERT_NEXT(a_respond_then_idle, clock, reset, cmd.respond, !busy)
   `ESRT_ASSERT_ALWAYS(a_one_write, clock, reset, $onehot0(wr_sel))

endmodule

/* src/event_sort_reverse_ties_core.sv */
// Batch event sorter. A push (req_cmd 0) inserts an event into a store kept in
// ascending timestamp order, with equal timestamps placed in front of earlier
// arrivals; a take (req_cmd 1) returns the next event in that order and flags
// the last one. A command is accepted at a clock edge with start high and busy
// low. Exactly one result follows each command, shown for a single cycle with
// rsp_strobe high; the receiver cannot stall it, so capture it on that edge.
// The result appears in the cycle busy falls. A take reads the next entry
// and then returns it, or reports empty at once when nothing is left. A push
// into a non-empty batch shifts the m held events with a timestamp at or above
// the new one up one place each, from the top down, one entry per cycle, then
// writes the new event below them. A push into an empty batch (including the
// first push of a new batch) and a dropped push (store full) respond at once.
module event_sort_reverse_ties_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_cmd,
   input  logic [esrt_pkg::TIME_W-1:0]    req_event_time,
   input  logic [esrt_pkg::TAG_OUT_W-1:0] req_event_tag,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_status,
   output logic [esrt_pkg::TIME_W-1:0]    rsp_out_time,
   output logic [esrt_pkg::TAG_OUT_W-1:0] rsp_out_tag,
   output logic                           rsp_final_one
);
   import esrt_pkg::*;

   esrt_cmd_type  cmd;
   esrt_stat_type stat;

   esrt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (stat),
      .cmd     (cmd),
      .busy    (busy)
   );

   esrt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_event_time (req_event_time),
      .req_event_tag  (req_event_tag),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_out_time   (rsp_out_time),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_final_one  (rsp_final_one)
   );

endmodule
